/* sv/mos_pkg.sv */
// ----------------------------------------------------------------------------
// mos_pkg
// Shared constants and types for the median-of-set block.
// ----------------------------------------------------------------------------
package mos_pkg;

  localparam int MAX_ELEMENTS = 512;
  localparam int VALUE_W      = 32;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int ADDR_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  // flipping the sign bit maps signed order onto unsigned order
  localparam logic [VALUE_W-1:0] SIGN_BIT = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] n;
    logic             ack;
  } sel_ctrl_t;

  typedef struct packed {
    logic               idle;
    logic               done;
    logic [VALUE_W-1:0] median;
  } sel_stat_t;

endpackage

/* sv/median_of_set.sv */
// ----------------------------------------------------------------------------
// median_of_set
// Collects a set of signed values and returns the upper median on the item
// flagged last; elements past the store depth are dropped and flagged.
// ----------------------------------------------------------------------------
//  channel | dir | tdata              | side band
//  s_*     | in  | [31:0] value       | tlast = last of set
//  m_*     | out | [31:0] median      | tuser[0] = overflowed
//
// An item without last is taken while the selector is idle. On the last item the
// selector makes 32 passes over the store, one result bit per pass; each pass
// issues n reads, waits out the read latency, closes the pass and then decides
// the bit. s_tready is low meanwhile and while a finished result waits for the
// output register. Reset clears the count, drop flag and handshake state; store
// contents need no clearing.
// ----------------------------------------------------------------------------
module median_of_set (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] median
  output logic [0:0]  m_tuser    // [0] overflowed
);

  logic [mos_pkg::CNT_W-1:0]   count;
  logic                        dropped;
  logic                        ovf_hold;
  logic                        full;
  logic                        take;
  logic                        load;
  logic [mos_pkg::VALUE_W-1:0] rdata;

  mos_pkg::mem_wr_t   wr;
  mos_pkg::mem_rd_t   rd;
  mos_pkg::sel_ctrl_t ctrl;
  mos_pkg::sel_stat_t stat;

  assign full     = (count == mos_pkg::CNT_W'(mos_pkg::MAX_ELEMENTS));
  assign s_tready = stat.idle;
  assign take     = s_tvalid && s_tready;
  assign load     = stat.done && (!m_tvalid || m_tready);

  assign wr.en   = take && !full;
  assign wr.addr = count[mos_pkg::ADDR_W-1:0];
  assign wr.data = s_tdata;

  assign ctrl.start = take && s_tlast;
  assign ctrl.n     = full ? count : (count + 1'b1);
  assign ctrl.ack   = load;

  mos_store u_store (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  mos_select u_select (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .stat  (stat),
    .rd    (rd),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      dropped  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        if (s_tlast) begin
          count    <= '0;
          dropped  <= 1'b0;
          ovf_hold <= dropped || full;
        end else if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata    <= stat.median;
      m_tuser[0] <= ovf_hold;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= mos_pkg::CNT_W'(mos_pkg::MAX_ELEMENTS))
    else $error("element count beyond store depth");

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input still ready after last item");

  assert property (@(posedge clk) disable iff (rst)
    stat.done |-> !s_tready)
    else $error("input ready while result pending");

  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(stat.done))
    else $error("result shown without finished selection");

endmodule

/* sv/mos_store.sv */
// ----------------------------------------------------------------------------
// mos_store
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mos_store (
  input  logic                          clk,
  input  mos_pkg::mem_wr_t              wr,
  input  mos_pkg::mem_rd_t              rd,
  output logic [mos_pkg::VALUE_W-1:0]   rdata
);

  logic [mos_pkg::VALUE_W-1:0] mem [mos_pkg::MAX_ELEMENTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

/* sv/mos_select.sv */
// ----------------------------------------------------------------------------
// mos_select
// Bit-serial radix selection: one result bit per pass over the store, MSB
// first, counting the candidates whose current bit is zero.
// ----------------------------------------------------------------------------
module mos_select (
  input  logic                          clk,
  input  logic                          rst,
  input  mos_pkg::sel_ctrl_t            ctrl,
  output mos_pkg::sel_stat_t            stat,
  output mos_pkg::mem_rd_t              rd,
  input  logic [mos_pkg::VALUE_W-1:0]   rdata
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PASS   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t                      state;
  logic [mos_pkg::CNT_W-1:0]   n;
  logic [mos_pkg::CNT_W-1:0]   addr;
  logic [mos_pkg::CNT_W-1:0]   rank;
  logic [mos_pkg::CNT_W-1:0]   cnt0;
  logic                        rd_vld;
  logic [mos_pkg::VALUE_W-1:0] cur;     // one-hot bit under decision, shifts right
  logic [mos_pkg::VALUE_W-1:0] mask;    // bits already decided
  logic [mos_pkg::VALUE_W-1:0] prefix;  // decided bits of the key

  logic                        issue;
  logic [mos_pkg::VALUE_W-1:0] key;
  logic                        match;
  logic                        bit_one;

  assign issue   = (state == S_PASS) && (addr != n);
  assign key     = rdata ^ mos_pkg::SIGN_BIT;
  assign match   = ((key & mask) == prefix);
  assign bit_one = (rank >= cnt0);

  assign rd.en   = issue;
  assign rd.addr = addr[mos_pkg::ADDR_W-1:0];

  assign stat.idle   = (state == S_IDLE);
  assign stat.done   = (state == S_DONE);
  assign stat.median = prefix ^ mos_pkg::SIGN_BIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
      case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            state  <= S_PASS;
            n      <= ctrl.n;
            rank   <= ctrl.n >> 1;
            addr   <= '0;
            cnt0   <= '0;
            cur    <= mos_pkg::SIGN_BIT;
            mask   <= '0;
            prefix <= '0;
          end
        end
        S_PASS: begin
          if (issue) begin
            addr <= addr + 1'b1;
          end
          if (rd_vld && match && ((key & cur) == '0)) begin
            cnt0 <= cnt0 + 1'b1;
          end
          if (!issue && !rd_vld) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          mask <= mask | cur;
          if (bit_one) begin
            prefix <= prefix | cur;
            rank   <= rank - cnt0;
          end
          cnt0 <= '0;
          addr <= '0;
          cur  <= cur >> 1;
          if (cur[0]) begin
            state <= S_DONE;
          end else begin
            state <= S_PASS;
          end
        end
        S_DONE: begin
          if (ctrl.ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* verif/median_of_set_test.sv */
// ----------------------------------------------------------------------------
// median_of_set_test
// Self-checking bench for the median-of-set block. It streams sets of signed
// values and keeps a running sorted copy of each set. When the last item of
// a set is accepted, the upper median and the drop flag are queued, then
// checked against the block's results in order. A short table of hand-picked
// sets comes first. Random sets of mostly small sizes follow, with two sets
// that reach the store depth. Both sides idle at random, and one long
// receiver stall backs the block up.
// ----------------------------------------------------------------------------
module median_of_set_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = mos_pkg::MAX_ELEMENTS;
  localparam int FIRST_FULL   = 150;      // random items before the full set
  localparam int SECOND_FULL  = 450;      // items since the table, full set counted
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_AT      = 14;       // result count that starts the long stall
  localparam int HOLD_CYCLES  = 3000;
  localparam int QUIET_LIMIT  = 100000;   // quiet spell that fails the bench
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [31:0] median;
    logic        overflowed;
  } median_result_t;

  typedef struct packed {
    logic [31:0]    value;
    logic           last;
    logic           typed;      // expected result written in the row
    median_result_t fixed;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // [31:0] value
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [31:0] median
  logic [0:0]  m_tuser;         // [0] overflowed

  median_of_set i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // running copy of the current set, ascending
  logic signed [31:0] sorted_vals [DEPTH];
  int                 held_count = 0;
  bit                 dropped = 1'b0;
  median_result_t     median_due [$];

  stim_row_t dir_rows [$];
  bit        steady_set = 1'b0;
  int        elements_sent = 0;
  int        sets_done = 0;
  int        drop_sets = 0;
  int        medians_checked = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("mismatch on result %0d: %s got %h want %h", medians_checked, what, got, want);
  endtask

  task automatic enter_element(input logic [31:0] v, input logic l,
                               output bit produced, output median_result_t res);
    int pos;
    produced = 1'b0;
    res = '0;
    if (held_count < DEPTH) begin
      pos = held_count;
      while (pos > 0 && sorted_vals[pos-1] > $signed(v)) begin
        sorted_vals[pos] = sorted_vals[pos-1];
        pos--;
      end
      sorted_vals[pos] = v;
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (l) begin
      res.median     = sorted_vals[held_count/2];
      res.overflowed = dropped;
      produced       = 1'b1;
      held_count     = 0;
      dropped        = 1'b0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom;
    // narrow band around zero gives ties and sign changes
    if (r < 88) return $urandom_range(0, 24) - 12;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      default: return 32'h0000_0000;
    endcase
  endfunction

  task automatic send_item(input logic [31:0] v, input logic l, input bit typed,
                           input median_result_t typed_exp);
    int             gap;
    bit             produced;
    median_result_t res;
    gap = steady_set ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    elements_sent++;
    enter_element(v, l, produced, res);
    if (produced) begin
      median_due.push_back(typed ? typed_exp : res);
      sets_done++;
      if (res.overflowed) drop_sets++;
    end
  endtask

  task automatic send_random_set(input int n);
    steady_set = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) send_item(pick_value(), i == n - 1, 1'b0, '0);
  endtask

  task automatic small_sets_until(input int base, input int limit);
    int r;
    while (elements_sent - base < limit) begin
      r = $urandom_range(0, 99);
      if (r < 70) send_random_set($urandom_range(1, 6));
      else if (r < 95) send_random_set($urandom_range(7, 20));
      else send_random_set($urandom_range(21, 48));
    end
  endtask

  task automatic add_row(input logic [31:0] v, input logic l, input logic typed,
                         input logic [31:0] med);
    stim_row_t row;
    row.value             = v;
    row.last              = l;
    row.typed             = typed;
    row.fixed.median      = med;
    row.fixed.overflowed  = 1'b0;
    dir_rows.push_back(row);
  endtask

  initial begin : stimulus
    int base;
    // single-element sets at the extremes and either side of zero
    add_row(32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000);
    add_row(32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff);
    add_row(32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000);
    add_row(32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff);
    // two elements: upper median is the larger; then three around zero
    add_row(32'h7fff_ffff, 1'b0, 1'b0, '0);
    add_row(32'h8000_0000, 1'b1, 1'b1, 32'h7fff_ffff);
    add_row(32'd5,         1'b0, 1'b0, '0);
    add_row(-32'sd5,       1'b0, 1'b0, '0);
    add_row(32'd0,         1'b1, 1'b1, 32'd0);
    // ties
    add_row(32'd7,         1'b0, 1'b0, '0);
    add_row(32'd7,         1'b0, 1'b0, '0);
    add_row(-32'sd3,       1'b0, 1'b0, '0);
    add_row(32'd7,         1'b1, 1'b0, '0);
    // even count, shuffled
    add_row(32'd3,         1'b0, 1'b0, '0);
    add_row(32'd1,         1'b0, 1'b0, '0);
    add_row(32'd4,         1'b0, 1'b0, '0);
    add_row(32'd2,         1'b1, 1'b0, '0);
    // descending across the sign boundary
    add_row(32'h7fff_ffff, 1'b0, 1'b0, '0);
    add_row(32'h4000_0000, 1'b0, 1'b0, '0);
    add_row(32'h0000_0000, 1'b0, 1'b0, '0);
    add_row(32'hc000_0000, 1'b0, 1'b0, '0);
    add_row(32'h8000_0001, 1'b1, 1'b0, '0);
    // alternating bit patterns, one of each sign
    add_row(32'haaaa_aaaa, 1'b0, 1'b0, '0);
    add_row(32'h5555_5555, 1'b1, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].fixed);

    base = elements_sent;
    small_sets_until(base, FIRST_FULL);
    send_random_set(DEPTH);          // fills the store exactly
    small_sets_until(base, SECOND_FULL);
    send_random_set(DEPTH + 3);      // last three dropped, last item among them
    small_sets_until(base, RANDOM_ITEMS);
    s_tvalid <= 1'b0;

    while (median_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d elements in %0d sets (%0d with dropped elements)",
             elements_sent, sets_done, drop_sets);
    $display("checked %0d medians, %0d mismatches", medians_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : drain
    int             idle_left;
    median_result_t want;
    idle_left = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (median_due.size() == 0) begin
          flag_mismatch("unexpected result", m_tdata, '0);
        end else begin
          want = median_due.pop_front();
          if (m_tdata !== want.median) flag_mismatch("median", m_tdata, want.median);
          if (m_tuser[0] !== want.overflowed)
            flag_mismatch("overflowed", 32'(m_tuser), 32'(want.overflowed));
        end
        medians_checked++;
        idle_left = (medians_checked == HOLD_AT) ? HOLD_CYCLES : pick_gap();
      end else if (idle_left == 0 && $urandom_range(0, 15) == 0) begin
        idle_left = pick_gap();
      end
      if (idle_left > 0) begin
        idle_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no item moved for %0d cycles", quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
